FILE: design/cgm_pkg.sv
// Shared types and constants for the colour gradient map.
package cgm_pkg;

  localparam int MAX_STOPS     = 8;
  localparam int FRACTION_BITS = 16;

  localparam int POS_IN_W  = 18;
  localparam int POS_W     = FRACTION_BITS + 1;
  localparam int CMP_W     = (POS_W > POS_IN_W - 1) ? POS_W : POS_IN_W - 1;
  localparam int SEG_W     = $clog2(MAX_STOPS);
  localparam int SCALED_W  = POS_W + SEG_W;
  localparam int PROD_W    = 8 + POS_W;
  localparam int SUM_W     = PROD_W + 1;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = 3;
  localparam int PAIR_W    = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_01    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_23    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_45    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_67    = 3'd4;

  typedef logic [23:0] rgb_t;

  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic [POS_W-1:0] frac;
  } seg_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

endpackage

FILE: design/cgm_scale.sv
// Front stages: clamp, scale by segment count, split into segment and fraction.
module cgm_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [cgm_pkg::POS_IN_W-1:0] position,
  input  logic [3:0]                        stop_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cgm_pkg::seg_t                     out_seg
);

  localparam logic [cgm_pkg::CMP_W-1:0] ONE_CMP =
    cgm_pkg::CMP_W'(1) << cgm_pkg::FRACTION_BITS;
  localparam logic [cgm_pkg::POS_W-1:0] ONE = cgm_pkg::POS_W'(1) << cgm_pkg::FRACTION_BITS;

  logic v1, v2, v3;
  logic en1, en2, en3;

  logic [cgm_pkg::POS_W-1:0]    pos1, pos_next;
  logic [cgm_pkg::SEG_W-1:0]    nm1_1, nm1_next, nm1_2;
  logic [cgm_pkg::SCALED_W-1:0] scaled2;
  cgm_pkg::seg_t                seg3, seg_next;

  logic [cgm_pkg::CMP_W-1:0] raw_mag;
  logic [cgm_pkg::SEG_W-1:0] seg_raw;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // clamp to 0..1.0 and saturate the stop count
  always_comb begin
    raw_mag = cgm_pkg::CMP_W'(position[cgm_pkg::POS_IN_W-2:0]);
    if (position[cgm_pkg::POS_IN_W-1]) begin
      pos_next = '0;
    end else if (raw_mag > ONE_CMP) begin
      pos_next = ONE;
    end else begin
      pos_next = cgm_pkg::POS_W'(raw_mag);
    end
    if (stop_count == 4'd0) begin
      nm1_next = '0;
    end else if (32'(stop_count) > cgm_pkg::MAX_STOPS) begin
      nm1_next = cgm_pkg::SEG_W'(cgm_pkg::MAX_STOPS - 1);
    end else begin
      nm1_next = cgm_pkg::SEG_W'(stop_count - 4'd1);
    end
  end

  // segment capped at the last pair; fraction may reach 1.0 there
  always_comb begin
    seg_raw = scaled2[cgm_pkg::FRACTION_BITS +: cgm_pkg::SEG_W];
    if (nm1_2 == '0) begin
      seg_next.seg = '0;
    end else if (seg_raw > nm1_2 - 1'b1) begin
      seg_next.seg = nm1_2 - 1'b1;
    end else begin
      seg_next.seg = seg_raw;
    end
    seg_next.frac = cgm_pkg::POS_W'(scaled2 -
      (cgm_pkg::SCALED_W'(seg_next.seg) << cgm_pkg::FRACTION_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      pos1  <= pos_next;
      nm1_1 <= nm1_next;
    end
    if (en2 && v1) begin
      scaled2 <= cgm_pkg::SCALED_W'(pos1) * cgm_pkg::SCALED_W'(nm1_1);
      nm1_2   <= nm1_1;
    end
    if (en3 && v2) begin
      seg3 <= seg_next;
    end
  end

  assign out_valid = v3;
  assign out_seg   = seg3;

endmodule

FILE: design/cgm_blend.sv
// Back stages: fetch the two stops, weight each channel, sum and truncate.
module cgm_blend (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cgm_pkg::seg_t  in_seg,
  input  cgm_pkg::rgb_t  stops [cgm_pkg::NUM_SLOTS],
  output logic           out_valid,
  input  logic           out_ready,
  output cgm_pkg::color_t out_color
);

  localparam logic [cgm_pkg::POS_W-1:0] ONE = cgm_pkg::POS_W'(1) << cgm_pkg::FRACTION_BITS;

  logic v4, v5;
  logic en4, en5;

  logic [cgm_pkg::SLOT_W-1:0] idx0, idx1;
  cgm_pkg::rgb_t              c0, c1;
  logic [cgm_pkg::POS_W-1:0]  wgt0;

  logic [cgm_pkg::PROD_W-1:0] p0 [3];
  logic [cgm_pkg::PROD_W-1:0] p1 [3];
  logic [cgm_pkg::SUM_W-1:0]  sum [3];
  logic [23:0]                res_next;
  cgm_pkg::color_t            res;

  assign en5      = !v5 || out_ready;
  assign en4      = !v4 || en5;
  assign in_ready = en4;

  assign idx0 = cgm_pkg::SLOT_W'(in_seg.seg);
  assign idx1 = idx0 + 1'b1;
  assign c0   = stops[idx0];
  assign c1   = stops[idx1];
  assign wgt0 = ONE - in_seg.frac;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = cgm_pkg::SUM_W'(p0[ch]) + cgm_pkg::SUM_W'(p1[ch]);
      res_next[ch*8 +: 8] = sum[ch][cgm_pkg::FRACTION_BITS +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en4) v4 <= in_valid;
      if (en5) v5 <= v4;
    end
  end

  // channel 0 is red (stop bits 23:16), 2 is blue
  always_ff @(posedge clk) begin
    if (en4 && in_valid) begin
      for (int ch = 0; ch < 3; ch++) begin
        p0[ch] <= cgm_pkg::PROD_W'(c0[(2-ch)*8 +: 8]) * cgm_pkg::PROD_W'(wgt0);
        p1[ch] <= cgm_pkg::PROD_W'(c1[(2-ch)*8 +: 8]) * cgm_pkg::PROD_W'(in_seg.frac);
      end
    end
    if (en5 && v4) begin
      res <= res_next;
    end
  end

  assign out_valid = v5;
  assign out_color = res;

endmodule

FILE: design/color_gradient_map.sv
// Top level of the colour gradient map: config registers and the two pipeline halves.
//
// Maps a signed position (16 fraction bits, clamped to 0..1.0) to an RGB colour on a
// gradient of 1 to 8 stops. One word is taken per clock unless the pipeline is backed up;
// each word passes five register stages (clamp, scale multiply, segment split, channel
// multiplies, sum). tready drops only when the pipeline is full and
// the output is stalled. Stops and stop_count may be written only while the block is
// idle; a write takes effect on the next clock.
module color_gradient_map (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // position [17:0], zero [23:18]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic                              cfg_wr_en,
  input  logic [cgm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cgm_pkg::PAIR_W-1:0]        cfg_data
);

  logic [3:0]                  stop_count;
  logic [cgm_pkg::PAIR_W-1:0]  pairs [4];
  cgm_pkg::rgb_t               stops [cgm_pkg::NUM_SLOTS];

  logic          mid_valid, mid_ready;
  cgm_pkg::seg_t mid_seg;
  cgm_pkg::color_t color;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= 4'd2;
      pairs[0]   <= 48'hFFFFFF000000;
      pairs[1]   <= '0;
      pairs[2]   <= '0;
      pairs[3]   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cgm_pkg::REG_STOP_COUNT: stop_count <= cfg_data[3:0];
        cgm_pkg::REG_PAIR_01:    pairs[0]   <= cfg_data;
        cgm_pkg::REG_PAIR_23:    pairs[1]   <= cfg_data;
        cgm_pkg::REG_PAIR_45:    pairs[2]   <= cfg_data;
        cgm_pkg::REG_PAIR_67:    pairs[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      stops[2*i]   = pairs[i][23:0];
      stops[2*i+1] = pairs[i][47:24];
    end
  end

  cgm_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .position   (s_tdata[cgm_pkg::POS_IN_W-1:0]),
    .stop_count (stop_count),
    .out_valid  (mid_valid),
    .out_ready  (mid_ready),
    .out_seg    (mid_seg)
  );

  cgm_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_seg    (mid_seg),
    .stops     (stops),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_color (color)
  );

  assign m_tdata = color;

endmodule

FILE: bench/tb_color_gradient_map.sv
// Self-checking bench for color_gradient_map: directed and random positions over many stop sets.
`timescale 1ns / 100ps

module tb_color_gradient_map;

  localparam int LONG_HOLD = 80;
  localparam int PHASES    = 12;
  localparam int PHASE_LEN = 60;

  // Holds the live stop set and the colours still owed by the block.
  class gradient_tracker;
    logic [3:0]                 stop_cnt;
    logic [cgm_pkg::PAIR_W-1:0] pairs [4];
    cgm_pkg::color_t            owed_colours [$];
    int                         mismatches;

    function new();
      stop_cnt   = 4'd2;
      pairs[0]   = 48'hFFFFFF000000;
      pairs[1]   = '0;
      pairs[2]   = '0;
      pairs[3]   = '0;
      mismatches = 0;
    endfunction

    function void set_register(logic [cgm_pkg::CFG_IDX_W-1:0] idx,
                               logic [cgm_pkg::PAIR_W-1:0] val);
      case (idx)
        cgm_pkg::REG_STOP_COUNT: stop_cnt = val[3:0];
        cgm_pkg::REG_PAIR_01:    pairs[0] = val;
        cgm_pkg::REG_PAIR_23:    pairs[1] = val;
        cgm_pkg::REG_PAIR_45:    pairs[2] = val;
        cgm_pkg::REG_PAIR_67:    pairs[3] = val;
        default: ;
      endcase
    endfunction

    function cgm_pkg::rgb_t stop_colour(int unsigned k);
      logic [cgm_pkg::PAIR_W-1:0] p;
      p = pairs[(k >> 1) & 3];
      return k[0] ? p[47:24] : p[23:0];
    endfunction

    function logic [7:0] blend(logic [7:0] a, logic [7:0] b, int unsigned frac);
      int unsigned one, sum;
      one = 1 << cgm_pkg::FRACTION_BITS;
      sum = a * (one - frac) + b * frac;
      return 8'(sum >> cgm_pkg::FRACTION_BITS);
    endfunction

    function cgm_pkg::color_t map_position(logic [17:0] raw);
      int unsigned     one, pos, n, scaled, seg, frac;
      cgm_pkg::rgb_t   lo, hi;
      cgm_pkg::color_t c;
      one = 1 << cgm_pkg::FRACTION_BITS;
      if (raw[17])
        pos = 0;
      else
        pos = (raw > one) ? one : raw;
      n = stop_cnt;
      if (n == 0) n = 1;
      if (n > cgm_pkg::MAX_STOPS) n = cgm_pkg::MAX_STOPS;
      if (n == 1) begin
        lo      = stop_colour(0);
        c.red   = lo[23:16];
        c.green = lo[15:8];
        c.blue  = lo[7:0];
        return c;
      end
      scaled = pos * (n - 1);
      seg    = scaled >> cgm_pkg::FRACTION_BITS;
      if (seg > n - 2) seg = n - 2;
      frac   = scaled - (seg << cgm_pkg::FRACTION_BITS);
      lo      = stop_colour(seg);
      hi      = stop_colour(seg + 1);
      c.red   = blend(lo[23:16], hi[23:16], frac);
      c.green = blend(lo[15:8],  hi[15:8],  frac);
      c.blue  = blend(lo[7:0],   hi[7:0],   frac);
      return c;
    endfunction

    function void note_position(logic [17:0] raw);
      owed_colours.push_back(map_position(raw));
    endfunction

    function void check_colour(cgm_pkg::color_t got);
      cgm_pkg::color_t want;
      if (owed_colours.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: r=%0h g=%0h b=%0h", got.red, got.green, got.blue);
        return;
      end
      want = owed_colours.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        mismatches++;
        if (mismatches <= 10)
          $display("colour mismatch: expected r=%0h g=%0h b=%0h, got r=%0h g=%0h b=%0h",
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
    endfunction

    function int owed();
      return owed_colours.size();
    endfunction
  endclass

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [23:0]                   s_tdata   = '0;
  logic                          m_tvalid;
  logic                          m_tready  = 1'b0;
  logic [23:0]                   m_tdata;
  logic                          cfg_wr_en = 1'b0;
  logic [cgm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cgm_pkg::PAIR_W-1:0]    cfg_data  = '0;

  bit hold_request = 1'b0;

  gradient_tracker trk = new();

  color_gradient_map u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Pre-edge values are seen here, so acceptance is judged race-free.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) trk.note_position(s_tdata[17:0]);
      if (m_tvalid && m_tready) trk.check_colour(cgm_pkg::color_t'(m_tdata));
    end
  end

  task automatic push_position(logic [17:0] pos);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, pos};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic pause(int cycles);
    s_tvalid <= 1'b0;
    s_tdata  <= {6'b0, 18'($urandom)};
    repeat (cycles) @(posedge clk);
  endtask

  // wait on the clock first, so the last accepted word is already on the owed list
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (trk.owed() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [cgm_pkg::CFG_IDX_W-1:0] idx,
                           logic [cgm_pkg::PAIR_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    trk.set_register(idx, val);
  endtask

  task automatic end_writes();
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [cgm_pkg::PAIR_W-1:0] random_pair();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return {24'hFFFFFF, 24'h000000};
      default: return r[47:0];
    endcase
  endfunction

  function automatic logic [17:0] random_position();
    case ($urandom_range(0, 9))
      0:       return 18'd0;
      1:       return 18'd65536;
      2:       return {1'b1, 17'($urandom)};
      3:       return 18'($urandom_range(65537, 131071));
      4:       return 18'($urandom);
      default: return 18'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic send_random(int count, bit gaps);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if (gaps && $urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
      end
      push_position(random_position());
      burst--;
    end
  endtask

  // Receiver: changes stall pattern now and then; a long hold-off on request.
  initial begin : receiver
    int         mode, left, step;
    logic [7:0] mask;
    left = 0;
    step = 0;
    mode = 0;
    mask = 8'hFF;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(20, 150);
          mask = 8'($urandom) | 8'h01;
        end
        left--;
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 99) < 65);
          default: begin
            m_tready <= mask[step % 8];
            step++;
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [3:0] cnt;
    int         v;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset stops: black to white over two stops, clamps at both ends
    push_position(18'd0);
    push_position(18'd65536);
    push_position(18'd32768);
    push_position(18'h3FFFF);
    push_position(18'h20000);
    push_position(18'h1FFFF);
    push_position(18'd65535);
    push_position(18'd65537);
    push_position(18'd1);
    drain();

    // eight stops, segment edges
    write_reg(cgm_pkg::REG_STOP_COUNT, 48'd8);
    write_reg(cgm_pkg::REG_PAIR_01, {24'hFFFFFF, 24'h000000});
    write_reg(cgm_pkg::REG_PAIR_23, {24'h00FF00, 24'hFF0000});
    write_reg(cgm_pkg::REG_PAIR_45, {24'h0000FF, 24'h123456});
    write_reg(cgm_pkg::REG_PAIR_67, {24'hFFFFFF, 24'h80C040});
    end_writes();
    push_position(18'd0);
    push_position(18'd9362);
    push_position(18'd9363);
    push_position(18'd28087);
    push_position(18'd46811);
    push_position(18'd56174);
    push_position(18'd65535);
    push_position(18'd65536);
    drain();

    // single stop, with junk above the count field
    write_reg(cgm_pkg::REG_STOP_COUNT, 48'hFFFF_FFFF_FFF1);
    end_writes();
    push_position(18'd32768);
    push_position(18'd65536);
    drain();

    // zero stops behaves as one
    write_reg(cgm_pkg::REG_STOP_COUNT, 48'd0);
    end_writes();
    push_position(18'd0);
    push_position(18'h1FFFF);
    drain();

    // counts above the maximum saturate
    write_reg(cgm_pkg::REG_STOP_COUNT, 48'd15);
    end_writes();
    push_position(18'd65536);
    push_position(18'd40000);
    drain();
    write_reg(cgm_pkg::REG_STOP_COUNT, 48'd9);
    for (int i = cgm_pkg::REG_PAIR_67 + 1; i < 8; i++)
      write_reg(cgm_pkg::CFG_IDX_W'(i), random_pair());
    end_writes();
    push_position(18'd30000);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      v = $urandom_range(0, 19);
      if (v < 12)      cnt = 4'($urandom_range(2, 8));
      else if (v < 14) cnt = 4'd1;
      else             cnt = 4'($urandom_range(0, 15));
      write_reg(cgm_pkg::REG_STOP_COUNT,
                ($urandom_range(0, 3) == 0) ? {random_pair()} & ~48'hF | cnt
                                            : 48'(cnt));
      write_reg(cgm_pkg::REG_PAIR_01, random_pair());
      write_reg(cgm_pkg::REG_PAIR_23, random_pair());
      write_reg(cgm_pkg::REG_PAIR_45, random_pair());
      write_reg(cgm_pkg::REG_PAIR_67, random_pair());
      if ($urandom_range(0, 3) == 0)
        write_reg(cgm_pkg::CFG_IDX_W'($urandom_range(cgm_pkg::REG_PAIR_67 + 1, 7)),
                  random_pair());
      end_writes();
      if (p == 5) begin
        // receiver holds off while words keep coming, so the pipe backs up
        hold_request = 1'b1;
        send_random(PHASE_LEN, 1'b0);
      end else if (p == 7) begin
        send_random(PHASE_LEN / 2, 1'b1);
        drain();
        send_random(PHASE_LEN / 2, 1'b1);
      end else begin
        send_random(PHASE_LEN, p != 9);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (trk.mismatches == 0 && trk.owed() == 0)
      $display("color_gradient_map regression: pass");
    else
      $display("color_gradient_map regression: fail");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("color_gradient_map regression: fail");
    $finish;
  end

endmodule

FILE: color_gradient_map.f
design/cgm_pkg.sv
design/cgm_scale.sv
design/cgm_blend.sv
design/color_gradient_map.sv
bench/tb_color_gradient_map.sv
